/* hw/rtl/bvs_pkg.sv */
// Shared types and constants for the bus voltage supervisor.
`default_nettype none

package bvs_pkg;

   // Fixed field widths of the ports and configuration registers.
   localparam int SAMPLE_PORT_BITS = 12;
   localparam int LEVEL_BITS       = 12;
   localparam int ALPHA_BITS       = 16;
   localparam int THRESH_BITS      = 12;
   localparam int LIMIT_BITS       = 14;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_ALPHA    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVER_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNDER_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVER_LIMIT      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNDER_LIMIT     = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [ALPHA_BITS-1:0]  RESET_FILTER_ALPHA    = 16'd3277;
   localparam logic [THRESH_BITS-1:0] RESET_OVER_THRESHOLD  = 12'd4095;
   localparam logic [THRESH_BITS-1:0] RESET_UNDER_THRESHOLD = 12'd0;
   localparam logic [LIMIT_BITS-1:0]  RESET_OVER_LIMIT      = 14'd10000;
   localparam logic [LIMIT_BITS-1:0]  RESET_UNDER_LIMIT     = 14'd2000;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [ALPHA_BITS-1:0]  filter_alpha;
      logic [THRESH_BITS-1:0] over_threshold;
      logic [THRESH_BITS-1:0] under_threshold;
      logic [LIMIT_BITS-1:0]  over_limit;
      logic [LIMIT_BITS-1:0]  under_limit;
   } cfg_type;

   // Threshold conditions of the freshly filtered value.
   typedef struct packed {
      logic over;
      logic under;
   } cond_type;

endpackage

`default_nettype wire

/* hw/rtl/bvs_csr.sv */
// Configuration register file of the bus voltage supervisor.
`default_nettype none

module bvs_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [bvs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bvs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output bvs_pkg::cfg_type                          cfg
);

   bvs_pkg::cfg_type cfg_ff;
   bvs_pkg::cfg_type cfg_in;

   // Decode the write; an index past the last register leaves everything alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            bvs_pkg::CSR_FILTER_ALPHA: begin
               cfg_in.filter_alpha = csr_wdata[bvs_pkg::ALPHA_BITS-1:0];
            end
            bvs_pkg::CSR_OVER_THRESHOLD: begin
               cfg_in.over_threshold = csr_wdata[bvs_pkg::THRESH_BITS-1:0];
            end
            bvs_pkg::CSR_UNDER_THRESHOLD: begin
               cfg_in.under_threshold = csr_wdata[bvs_pkg::THRESH_BITS-1:0];
            end
            bvs_pkg::CSR_OVER_LIMIT: begin
               cfg_in.over_limit = csr_wdata[bvs_pkg::LIMIT_BITS-1:0];
            end
            bvs_pkg::CSR_UNDER_LIMIT: begin
               cfg_in.under_limit = csr_wdata[bvs_pkg::LIMIT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Register bank with its documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha    <= bvs_pkg::RESET_FILTER_ALPHA;
         cfg_ff.over_threshold  <= bvs_pkg::RESET_OVER_THRESHOLD;
         cfg_ff.under_threshold <= bvs_pkg::RESET_UNDER_THRESHOLD;
         cfg_ff.over_limit      <= bvs_pkg::RESET_OVER_LIMIT;
         cfg_ff.under_limit     <= bvs_pkg::RESET_UNDER_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/bvs_filter.sv */
// First-order low-pass filter with threshold compares.
`default_nettype none

module bvs_filter #(
   parameter int SAMPLE_BITS   = 12,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  enable,
   input  wire logic [bvs_pkg::SAMPLE_PORT_BITS-1:0]  sample,
   input  bvs_pkg::cfg_type                           cfg,
   output bvs_pkg::cond_type                          cond,
   output logic [bvs_pkg::LEVEL_BITS-1:0]             level
);

   localparam int FILT_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int PROD_BITS = FILT_BITS + bvs_pkg::ALPHA_BITS;
   localparam int INT_BITS  = (SAMPLE_BITS > bvs_pkg::THRESH_BITS) ?
                              SAMPLE_BITS : bvs_pkg::THRESH_BITS;
   localparam int CMP_BITS  = INT_BITS + FRACTION_BITS;
   localparam int OUT_BITS  = (SAMPLE_BITS > bvs_pkg::LEVEL_BITS) ?
                              SAMPLE_BITS : bvs_pkg::LEVEL_BITS;

   logic [FILT_BITS-1:0] filt_ff;
   logic [FILT_BITS-1:0] filt_in;
   logic [FILT_BITS-1:0] target;
   logic                 rising;
   logic [FILT_BITS-1:0] diff;
   logic [PROD_BITS-1:0] prod;
   logic [FILT_BITS-1:0] step;
   logic [FILT_BITS:0]   sum;
   logic [CMP_BITS-1:0]  filt_cmp;
   logic [CMP_BITS-1:0]  over_cmp;
   logic [CMP_BITS-1:0]  under_cmp;
   logic [OUT_BITS-1:0]  level_wide;

   // Distance to the sample, taken as a magnitude with its direction.
   assign target = {SAMPLE_BITS'(sample), {FRACTION_BITS{1'b0}}};
   assign rising = (target >= filt_ff);
   assign diff   = rising ? (target - filt_ff) : (filt_ff - target);

   // Scale by alpha; dropping the low bits truncates toward zero.
   assign prod = PROD_BITS'(cfg.filter_alpha) * PROD_BITS'(diff);
   assign step = prod[PROD_BITS-1:bvs_pkg::ALPHA_BITS];

   // Move toward the sample, saturating at full scale.
   assign sum = {1'b0, filt_ff} + {1'b0, step};
   always_comb begin
      if (rising) begin
         filt_in = sum[FILT_BITS] ? {FILT_BITS{1'b1}} : sum[FILT_BITS-1:0];
      end else begin
         filt_in = filt_ff - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
      end else if (enable) begin
         filt_ff <= filt_in;
      end
   end

   // Compare the updated value against thresholds in converter codes.
   assign filt_cmp   = CMP_BITS'(filt_in);
   assign over_cmp   = CMP_BITS'({cfg.over_threshold, {FRACTION_BITS{1'b0}}});
   assign under_cmp  = CMP_BITS'({cfg.under_threshold, {FRACTION_BITS{1'b0}}});
   assign cond.over  = (filt_cmp > over_cmp);
   assign cond.under = (filt_cmp < under_cmp);

   // Integer part of the updated value.
   assign level_wide = OUT_BITS'(filt_in[FILT_BITS-1:FRACTION_BITS]);
   assign level      = level_wide[bvs_pkg::LEVEL_BITS-1:0];

endmodule

`default_nettype wire

/* hw/rtl/bvs_counter.sv */
// Consecutive-tick counter that pulses a fault at its limit.
`default_nettype none

module bvs_counter #(
   parameter int COUNT_BITS = 14
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             cond,
   input  wire logic [bvs_pkg::LIMIT_BITS-1:0]   limit,
   output logic                                  fault
);

   localparam int CMP_BITS = (COUNT_BITS > bvs_pkg::LIMIT_BITS) ?
                             COUNT_BITS : bvs_pkg::LIMIT_BITS;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  hit;

   // Saturating increment, then check against the limit.
   assign count_inc = (count_ff == {COUNT_BITS{1'b1}}) ? count_ff : count_ff + 1'b1;
   assign hit       = (CMP_BITS'(count_inc) >= CMP_BITS'(limit));

   // An absent condition or a reached limit clears the counter.
   always_comb begin
      priority if (!cond) begin
         count_in = '0;
      end else if (hit) begin
         count_in = '0;
      end else begin
         count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (enable) begin
         count_ff <= count_in;
      end
   end

   assign fault = enable && cond && hit;

endmodule

`default_nettype wire

/* hw/rtl/bus_voltage_supervisor.sv */
// Top level of the bus voltage supervisor: handshake stages and datapath.
//
// The supervisor takes one bus voltage sample word per cycle unless stalled and
// returns one result word per sample: the integer part of the low-pass filtered
// level and two one-tick fault flags. A word passes the input register, then the
// result register that drives the result port; a result-channel stall holds it
// in the input register. The filter multiply-accumulate and both tick counters
// close their feedback through one register each, setting the sustained rate of
// one word per cycle. Fault counters advance only for motor_active words.
// After reset alpha is 3277 (about 0.05), the over threshold 4095, the under
// threshold 0, the over limit 10000 and the under limit 2000 ticks.
// Configuration writes are meant for times when no word is in flight.
`default_nettype none

module bus_voltage_supervisor #(
   parameter int SAMPLE_BITS   = 12,
   parameter int FRACTION_BITS = 16,
   parameter int COUNT_BITS    = 14
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration port
   input  wire logic                                  csr_wen,
   input  wire logic [bvs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [bvs_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   // Sample channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [bvs_pkg::SAMPLE_PORT_BITS-1:0]  req_vbus_sample,
   input  wire logic                                  req_motor_active,
   // Result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [bvs_pkg::LEVEL_BITS-1:0]             rsp_filtered_level,
   output logic                                       rsp_overvoltage_fault,
   output logic                                       rsp_undervoltage_fault
);

   bvs_pkg::cfg_type  cfg;
   bvs_pkg::cond_type cond;

   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic [bvs_pkg::SAMPLE_PORT_BITS-1:0]  in_sample_ff;
   logic                                  in_active_ff;
   logic                                  req_accept;
   logic                                  out_load;

   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic [bvs_pkg::LEVEL_BITS-1:0]        rsp_level_ff;
   logic                                  rsp_over_ff;
   logic                                  rsp_under_ff;

   logic [bvs_pkg::LEVEL_BITS-1:0]        level;
   logic                                  count_enable;
   logic                                  over_fault;
   logic                                  under_fault;

   // Configuration registers.
   bvs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: the result register frees up when it is empty or being taken.
   assign out_load     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !out_load;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff <= req_vbus_sample;
         in_active_ff <= req_motor_active;
      end
   end

   // Filter; its state advances once per word moved to the result register.
   bvs_filter #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_filter (
      .clock  (clock),
      .reset  (reset),
      .enable (out_load),
      .sample (in_sample_ff),
      .cfg    (cfg),
      .cond   (cond),
      .level  (level)
   );

   // Tick counters hold while the motor is inactive.
   assign count_enable = out_load && in_active_ff;

   bvs_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_over_counter (
      .clock  (clock),
      .reset  (reset),
      .enable (count_enable),
      .cond   (cond.over),
      .limit  (cfg.over_limit),
      .fault  (over_fault)
   );

   bvs_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_under_counter (
      .clock  (clock),
      .reset  (reset),
      .enable (count_enable),
      .cond   (cond.under),
      .limit  (cfg.under_limit),
      .fault  (under_fault)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_level_ff <= level;
         rsp_over_ff  <= over_fault;
         rsp_under_ff <= under_fault;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_filtered_level     = rsp_level_ff;
   assign rsp_overvoltage_fault  = rsp_over_ff;
   assign rsp_undervoltage_fault = rsp_under_ff;

`ifndef SYNTH
   // The sample side is only held off while a word waits in the input register.
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("sample channel stalled with an empty input register");

   // A word moved forward always shows up as a valid result.
   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded word did not reach the result register");

   // A fault from the counters reaches the result word that carries it.
   a_over_fault_path: assert property (@(posedge clock) disable iff (reset)
      (out_load && over_fault) |=> (rsp_valid_ff && rsp_over_ff))
      else $error("overvoltage fault lost on its way to the result");

   // Faults only fire for words taken while the motor is active.
   a_fault_needs_active: assert property (@(posedge clock) disable iff (reset)
      (over_fault || under_fault) |-> (out_load && in_active_ff))
      else $error("fault raised for a word with the motor inactive");
`endif

endmodule

`default_nettype wire
